// ===== src/qsl_pkg.sv =====
// qsl_pkg: shared types, microcode encoding and the control store for the quicksort block.
// Used by qsl_useq, qsl_dpath and quicksort_lomuto; depends on nothing.
`default_nettype none

package qsl_pkg;

    localparam int VALUE_W = 32;
    localparam int UPC_W   = 5;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_INIT,
        OP_POP,
        OP_RANGE,
        OP_PIVOT,
        OP_SCAN,
        OP_HOLD,
        OP_SWAP_A,
        OP_SWAP_B,
        OP_INC,
        OP_FIN_RD,
        OP_FIN_A,
        OP_FIN_B,
        OP_PUSH_L,
        OP_PUSH_R,
        OP_EMIT_INIT,
        OP_SHOW,
        OP_EMIT_RD,
        OP_DONE
    } op_t;

    typedef enum logic [3:0] {
        C_NEXT,
        C_JUMP,
        C_LOADING,
        C_CNT_LT2,
        C_SP_ZERO,
        C_RANGE_BAD,
        C_K_GE_HI,
        C_NOT_LESS,
        C_OUT_PENDING,
        C_K_LT_CNT
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic in_close;
        logic cnt_lt2;
        logic sp_zero;
        logic range_bad;
        logic k_ge_hi;
        logic not_less;
        logic out_pending;
        logic k_lt_cnt;
    } stat_t;

    localparam logic [UPC_W-1:0] L_LOAD      = 5'd0;
    localparam logic [UPC_W-1:0] L_INIT      = 5'd1;
    localparam logic [UPC_W-1:0] L_POP       = 5'd2;
    localparam logic [UPC_W-1:0] L_RANGE     = 5'd3;
    localparam logic [UPC_W-1:0] L_PIVOT     = 5'd4;
    localparam logic [UPC_W-1:0] L_SCAN      = 5'd5;
    localparam logic [UPC_W-1:0] L_HOLD      = 5'd6;
    localparam logic [UPC_W-1:0] L_SWAP_A    = 5'd7;
    localparam logic [UPC_W-1:0] L_SWAP_B    = 5'd8;
    localparam logic [UPC_W-1:0] L_INC       = 5'd9;
    localparam logic [UPC_W-1:0] L_FIN_RD    = 5'd10;
    localparam logic [UPC_W-1:0] L_FIN_A     = 5'd11;
    localparam logic [UPC_W-1:0] L_FIN_B     = 5'd12;
    localparam logic [UPC_W-1:0] L_PUSH_L    = 5'd13;
    localparam logic [UPC_W-1:0] L_PUSH_R    = 5'd14;
    localparam logic [UPC_W-1:0] L_EMIT_INIT = 5'd15;
    localparam logic [UPC_W-1:0] L_SHOW      = 5'd16;
    localparam logic [UPC_W-1:0] L_EMIT_RD   = 5'd17;
    localparam logic [UPC_W-1:0] L_EMIT_TEST = 5'd18;
    localparam logic [UPC_W-1:0] L_DONE      = 5'd19;

    function automatic ctrl_t ucode_rom(input logic [UPC_W-1:0] addr);
        ctrl_t word;
        case (addr)
            L_LOAD:      word = '{op: OP_LOAD,      cond: C_LOADING,     target: L_LOAD};
            L_INIT:      word = '{op: OP_INIT,      cond: C_CNT_LT2,     target: L_EMIT_INIT};
            L_POP:       word = '{op: OP_POP,       cond: C_SP_ZERO,     target: L_EMIT_INIT};
            L_RANGE:     word = '{op: OP_RANGE,     cond: C_RANGE_BAD,   target: L_POP};
            L_PIVOT:     word = '{op: OP_PIVOT,     cond: C_NEXT,        target: L_SCAN};
            L_SCAN:      word = '{op: OP_SCAN,      cond: C_K_GE_HI,     target: L_FIN_RD};
            L_HOLD:      word = '{op: OP_HOLD,      cond: C_NOT_LESS,    target: L_INC};
            L_SWAP_A:    word = '{op: OP_SWAP_A,    cond: C_NEXT,        target: L_SWAP_B};
            L_SWAP_B:    word = '{op: OP_SWAP_B,    cond: C_JUMP,        target: L_SCAN};
            L_INC:       word = '{op: OP_INC,       cond: C_JUMP,        target: L_SCAN};
            L_FIN_RD:    word = '{op: OP_FIN_RD,    cond: C_NEXT,        target: L_FIN_A};
            L_FIN_A:     word = '{op: OP_FIN_A,     cond: C_NEXT,        target: L_FIN_B};
            L_FIN_B:     word = '{op: OP_FIN_B,     cond: C_NEXT,        target: L_PUSH_L};
            L_PUSH_L:    word = '{op: OP_PUSH_L,    cond: C_NEXT,        target: L_PUSH_R};
            L_PUSH_R:    word = '{op: OP_PUSH_R,    cond: C_JUMP,        target: L_POP};
            L_EMIT_INIT: word = '{op: OP_EMIT_INIT, cond: C_NEXT,        target: L_SHOW};
            L_SHOW:      word = '{op: OP_SHOW,      cond: C_NEXT,        target: L_EMIT_RD};
            L_EMIT_RD:   word = '{op: OP_EMIT_RD,   cond: C_OUT_PENDING, target: L_EMIT_RD};
            L_EMIT_TEST: word = '{op: OP_NOP,       cond: C_K_LT_CNT,    target: L_SHOW};
            L_DONE:      word = '{op: OP_DONE,      cond: C_JUMP,        target: L_LOAD};
            default:     word = '{op: OP_DONE,      cond: C_JUMP,        target: L_LOAD};
        endcase
        return word;
    endfunction

endpackage

`default_nettype wire

// ===== src/qsl_useq.sv =====
// qsl_useq: micro-sequencer with step counter, control store lookup and conditional jumps.
// Depends on qsl_pkg (control word, status and control store).
`default_nettype none

module qsl_useq
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire qsl_pkg::stat_t  stat,
    output qsl_pkg::ctrl_t       ctrl
);

    logic [qsl_pkg::UPC_W-1:0] upc_reg;
    logic [qsl_pkg::UPC_W-1:0] upc_next;
    logic                      take;

    assign ctrl = qsl_pkg::ucode_rom(upc_reg);

    always_comb
    begin
        case (ctrl.cond)
            qsl_pkg::C_NEXT:        take = 1'b0;
            qsl_pkg::C_JUMP:        take = 1'b1;
            qsl_pkg::C_LOADING:     take = !stat.in_close;
            qsl_pkg::C_CNT_LT2:     take = stat.cnt_lt2;
            qsl_pkg::C_SP_ZERO:     take = stat.sp_zero;
            qsl_pkg::C_RANGE_BAD:   take = stat.range_bad;
            qsl_pkg::C_K_GE_HI:     take = stat.k_ge_hi;
            qsl_pkg::C_NOT_LESS:    take = stat.not_less;
            qsl_pkg::C_OUT_PENDING: take = stat.out_pending;
            qsl_pkg::C_K_LT_CNT:    take = stat.k_lt_cnt;
            default:                take = 1'b0;
        endcase
        upc_next = take ? ctrl.target : qsl_pkg::UPC_W'(upc_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= qsl_pkg::L_LOAD;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/qsl_dpath.sv =====
// qsl_dpath: element store, range stack, index registers and stream ports of the sorter.
// Driven by the control word from qsl_useq; depends on qsl_pkg.
`default_nettype none

module qsl_dpath
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire qsl_pkg::ctrl_t                ctrl,
    output qsl_pkg::stat_t                     stat,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [qsl_pkg::VALUE_W-1:0]   s_axis_tdata,
    input  wire logic                          s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [qsl_pkg::VALUE_W-1:0]        m_axis_tdata,
    output logic                               m_axis_tlast,
    output logic                               m_axis_tuser
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = 2 * IW;

    logic [DATA_WIDTH-1:0] elem_mem  [DEPTH];
    logic [SW-1:0]         stack_mem [DEPTH];

    logic [CW-1:0]         count_reg,   count_next;
    logic [CW-1:0]         sp_reg,      sp_next;
    logic                  dropped_reg, dropped_next;
    logic                  out_valid_reg, out_valid_next;

    logic [IW-1:0]         lo_reg,    lo_next;
    logic [IW-1:0]         hi_reg,    hi_next;
    logic [CW-1:0]         k_reg,     k_next;
    logic [IW-1:0]         slot_reg,  slot_next;
    logic [DATA_WIDTH-1:0] pivot_reg, pivot_next;
    logic [DATA_WIDTH-1:0] tmp_reg,   tmp_next;
    logic [qsl_pkg::VALUE_W-1:0] out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_user_reg, out_user_next;

    logic [DATA_WIDTH-1:0] elem_rdata_reg;
    logic [SW-1:0]         stack_rdata_reg;

    logic                  elem_we, elem_re;
    logic [IW-1:0]         elem_waddr, elem_raddr;
    logic [DATA_WIDTH-1:0] elem_wdata;
    logic                  stack_we, stack_re;
    logic [IW-1:0]         stack_waddr, stack_raddr;
    logic [SW-1:0]         stack_wdata;

    logic                  in_xfer, out_xfer;
    logic [DATA_WIDTH+qsl_pkg::VALUE_W-1:0] in_ext, out_ext;
    logic [IW-1:0]         pop_lo, pop_hi;
    logic [CW-1:0]         slot_w, lo_w, hi_w, k_inc;
    logic                  push_ok;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = out_valid_reg && m_axis_tready;
    assign in_ext   = {{DATA_WIDTH{1'b0}}, s_axis_tdata};
    assign out_ext  = {{qsl_pkg::VALUE_W{1'b0}}, elem_rdata_reg};
    assign pop_lo   = stack_rdata_reg[SW-1:IW];
    assign pop_hi   = stack_rdata_reg[IW-1:0];
    assign slot_w   = CW'(slot_reg);
    assign lo_w     = CW'(lo_reg);
    assign hi_w     = CW'(hi_reg);
    assign k_inc    = CW'(k_reg + 1'b1);
    assign push_ok  = sp_reg < CW'(DEPTH);

    assign s_axis_tready = (ctrl.op == qsl_pkg::OP_LOAD);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_user_reg;

    always_comb
    begin
        stat.in_close    = in_xfer && s_axis_tlast;
        stat.cnt_lt2     = count_reg < CW'(2);
        stat.sp_zero     = (sp_reg == '0);
        stat.range_bad   = (pop_lo >= pop_hi);
        stat.k_ge_hi     = (k_reg >= hi_w);
        stat.not_less    = !($signed(elem_rdata_reg) < $signed(pivot_reg));
        stat.out_pending = out_valid_reg && !m_axis_tready;
        stat.k_lt_cnt    = (k_reg < count_reg);
    end

    always_comb
    begin
        count_next     = count_reg;
        sp_next        = sp_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_xfer ? 1'b0 : out_valid_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        k_next         = k_reg;
        slot_next      = slot_reg;
        pivot_next     = pivot_reg;
        tmp_next       = tmp_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;
        elem_we        = 1'b0;
        elem_waddr     = slot_reg;
        elem_wdata     = tmp_reg;
        elem_re        = 1'b0;
        elem_raddr     = k_reg[IW-1:0];
        stack_we       = 1'b0;
        stack_waddr    = sp_reg[IW-1:0];
        stack_wdata    = {lo_reg, hi_reg};
        stack_re       = 1'b0;
        stack_raddr    = IW'(sp_reg - 1'b1);

        case (ctrl.op)
            qsl_pkg::OP_LOAD:
            begin
                if (in_xfer)
                begin
                    if (count_reg < CW'(DEPTH))
                    begin
                        elem_we    = 1'b1;
                        elem_waddr = count_reg[IW-1:0];
                        elem_wdata = in_ext[DATA_WIDTH-1:0];
                        count_next = CW'(count_reg + 1'b1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
            end
            qsl_pkg::OP_INIT:
            begin
                stack_we    = 1'b1;
                stack_waddr = '0;
                stack_wdata = {{IW{1'b0}}, IW'(count_reg - 1'b1)};
                sp_next     = CW'(1);
            end
            qsl_pkg::OP_POP:
            begin
                if (sp_reg != '0)
                begin
                    stack_re = 1'b1;
                    sp_next  = CW'(sp_reg - 1'b1);
                end
            end
            qsl_pkg::OP_RANGE:
            begin
                lo_next    = pop_lo;
                hi_next    = pop_hi;
                k_next     = CW'(pop_lo);
                slot_next  = pop_lo;
                elem_re    = 1'b1;
                elem_raddr = pop_hi;
            end
            qsl_pkg::OP_PIVOT:
            begin
                pivot_next = elem_rdata_reg;
            end
            qsl_pkg::OP_SCAN:
            begin
                elem_re    = 1'b1;
                elem_raddr = k_reg[IW-1:0];
            end
            qsl_pkg::OP_HOLD:
            begin
                tmp_next   = elem_rdata_reg;
                elem_re    = 1'b1;
                elem_raddr = slot_reg;
            end
            qsl_pkg::OP_SWAP_A:
            begin
                elem_we    = 1'b1;
                elem_waddr = slot_reg;
                elem_wdata = tmp_reg;
            end
            qsl_pkg::OP_SWAP_B:
            begin
                elem_we    = 1'b1;
                elem_waddr = k_reg[IW-1:0];
                elem_wdata = elem_rdata_reg;
                slot_next  = IW'(slot_reg + 1'b1);
                k_next     = k_inc;
            end
            qsl_pkg::OP_INC:
            begin
                k_next = k_inc;
            end
            qsl_pkg::OP_FIN_RD:
            begin
                elem_re    = 1'b1;
                elem_raddr = slot_reg;
            end
            qsl_pkg::OP_FIN_A:
            begin
                elem_we    = 1'b1;
                elem_waddr = hi_reg;
                elem_wdata = elem_rdata_reg;
            end
            qsl_pkg::OP_FIN_B:
            begin
                elem_we    = 1'b1;
                elem_waddr = slot_reg;
                elem_wdata = pivot_reg;
            end
            qsl_pkg::OP_PUSH_L:
            begin
                if (slot_w > CW'(lo_w + 1'b1) && push_ok)
                begin
                    stack_we    = 1'b1;
                    stack_wdata = {lo_reg, IW'(slot_reg - 1'b1)};
                    sp_next     = CW'(sp_reg + 1'b1);
                end
            end
            qsl_pkg::OP_PUSH_R:
            begin
                if (CW'(slot_w + 1'b1) < hi_w && push_ok)
                begin
                    stack_we    = 1'b1;
                    stack_wdata = {IW'(slot_reg + 1'b1), hi_reg};
                    sp_next     = CW'(sp_reg + 1'b1);
                end
            end
            qsl_pkg::OP_EMIT_INIT:
            begin
                k_next     = '0;
                elem_re    = 1'b1;
                elem_raddr = '0;
            end
            qsl_pkg::OP_SHOW:
            begin
                out_data_next  = out_ext[qsl_pkg::VALUE_W-1:0];
                out_last_next  = (k_inc == count_reg);
                out_user_next  = dropped_reg;
                out_valid_next = 1'b1;
                k_next         = k_inc;
            end
            qsl_pkg::OP_EMIT_RD:
            begin
                elem_re    = 1'b1;
                elem_raddr = k_reg[IW-1:0];
            end
            qsl_pkg::OP_DONE:
            begin
                count_next   = '0;
                sp_next      = '0;
                dropped_next = 1'b0;
            end
            default:
            begin
                elem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sp_reg        <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            sp_reg        <= sp_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        k_reg        <= k_next;
        slot_reg     <= slot_next;
        pivot_reg    <= pivot_next;
        tmp_reg      <= tmp_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[elem_waddr] <= elem_wdata;
        end
        if (elem_re)
        begin
            elem_rdata_reg <= elem_mem[elem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (stack_re)
        begin
            stack_rdata_reg <= stack_mem[stack_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/quicksort_lomuto.sv =====
// quicksort_lomuto: collect-then-sort block, Lomuto quicksort under microcode control.
// Loading: one element per cycle while s_axis_tready is high; the tlast transfer closes the set.
// Sort: per range a pop and a pivot read, per element a scan and hold, then a skip or a swap (one
// store port, two writes), then pivot placement and pushes. Emission: each result is shown and held
// until taken. Reset clears counters and the step counter; no clearing pass of the store.
// Depends on qsl_pkg, qsl_useq and qsl_dpath.
`default_nettype none

module quicksort_lomuto
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [qsl_pkg::VALUE_W-1:0]   s_axis_tdata,   // [31:0] value
    input  wire logic                          s_axis_tlast,   // is_last
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [qsl_pkg::VALUE_W-1:0]        m_axis_tdata,   // [31:0] sorted_value
    output logic                               m_axis_tlast,   // end_of_run
    output logic                               m_axis_tuser    // [0] overflowed
);

    qsl_pkg::ctrl_t ctrl;
    qsl_pkg::stat_t stat;

    qsl_useq u_useq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    qsl_dpath
    #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    )
    u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== src/qsl_checker.sv =====
// qsl_checker: port-level checks of the quicksort block, bound to quicksort_lomuto.
// Depends on the top-level port list only.
`default_nettype none

module qsl_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic        m_axis_tlast,
    input wire logic [31:0] m_axis_tdata
);

    a_load_or_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is shown");

    a_close_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input still ready after the closing transfer");

    a_run_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("result shown right after the final transfer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result dropped or changed");

endmodule

bind quicksort_lomuto qsl_checker u_qsl_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== bench/quicksort_lomuto_checker.sv =====
// quicksort_lomuto_checker: watches both streams of the sort block and checks every result.
// Collects each loaded set, predicts its ascending order and flags, and compares in order.
// Depends on qsl_pkg for the value width.

module quicksort_lomuto_checker
#(
    parameter int DEPTH = 64
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    input  wire logic [qsl_pkg::VALUE_W-1:0]   s_axis_tdata,
    input  wire logic                          s_axis_tlast,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [qsl_pkg::VALUE_W-1:0]   m_axis_tdata,
    input  wire logic                          m_axis_tlast,
    input  wire logic                          m_axis_tuser,
    output int                                 fail_count,
    output int                                 outstanding
);

    typedef struct packed {
        logic [qsl_pkg::VALUE_W-1:0] sorted_value;
        logic                        end_of_run;
        logic                        overflowed;
    } sorted_item_t;

    logic signed [qsl_pkg::VALUE_W-1:0] set_store [DEPTH];
    int                                 set_count    = 0;
    bit                                 set_lost     = 1'b0;
    int                                 mismatches   = 0;
    sorted_item_t                       sorted_q[$];

    always @(posedge clk)
    begin : watch
        logic signed [qsl_pkg::VALUE_W-1:0] key;
        sorted_item_t                       want;
        int                                 i;
        int                                 j;

        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (sorted_q.size() == 0)
                begin
                    $error("sorted_value: expected none, got %0d", $signed(m_axis_tdata));
                    mismatches++;
                end
                else
                begin
                    want = sorted_q.pop_front();
                    if (m_axis_tdata !== want.sorted_value)
                    begin
                        $error("sorted_value: expected %0d, got %0d",
                               $signed(want.sorted_value), $signed(m_axis_tdata));
                        mismatches++;
                    end
                    if (m_axis_tlast !== want.end_of_run)
                    begin
                        $error("end_of_run: expected %0d, got %0d",
                               want.end_of_run, m_axis_tlast);
                        mismatches++;
                    end
                    if (m_axis_tuser !== want.overflowed)
                    begin
                        $error("overflowed: expected %0d, got %0d",
                               want.overflowed, m_axis_tuser);
                        mismatches++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                // drop anything past a full store, the closing transfer included
                if (set_count < DEPTH)
                begin
                    set_store[set_count] = s_axis_tdata;
                    set_count++;
                end
                else
                    set_lost = 1'b1;

                if (s_axis_tlast)
                begin
                    for (i = 1; i < set_count; i++)
                    begin
                        key = set_store[i];
                        j = i - 1;
                        while (j >= 0 && set_store[j] > key)
                        begin
                            set_store[j + 1] = set_store[j];
                            j--;
                        end
                        set_store[j + 1] = key;
                    end
                    for (i = 0; i < set_count; i++)
                    begin
                        want.sorted_value = set_store[i];
                        want.end_of_run   = (i == set_count - 1);
                        want.overflowed   = set_lost;
                        sorted_q.push_back(want);
                    end
                    set_count = 0;
                    set_lost  = 1'b0;
                end
            end

            outstanding <= sorted_q.size();
            fail_count  <= mismatches;
        end
    end

endmodule

// ===== bench/quicksort_lomuto_tb.sv =====
// quicksort_lomuto_tb: drives sets of signed values into the sort block with random gaps
// and back-pressure, then reports the verdict. Depends on qsl_pkg, quicksort_lomuto
// and quicksort_lomuto_checker.

module quicksort_lomuto_tb;

    localparam int DEPTH        = 64;
    localparam int RANDOM_ITEMS = 300;
    localparam int HOLD_AT      = 30;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 60000;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {
        FILL_RANDOM,
        FILL_NARROW,
        FILL_EXTREME,
        FILL_RISING,
        FILL_FALLING
    } fill_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [qsl_pkg::VALUE_W-1:0]   s_axis_tdata;
    logic                          s_axis_tlast;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [qsl_pkg::VALUE_W-1:0]   m_axis_tdata;
    logic                          m_axis_tlast;
    logic                          m_axis_tuser;
    int                            fail_count;
    int                            outstanding;

    logic [qsl_pkg::VALUE_W-1:0]   set_values[$];
    bit                            tx_calm = 1'b0;
    int                            items_sent = 0;
    int                            quiet_cycles = 0;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    quicksort_lomuto #(.DEPTH(DEPTH), .DATA_WIDTH(qsl_pkg::VALUE_W)) DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    quicksort_lomuto_checker #(.DEPTH(DEPTH)) u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    task automatic fill_set(input int size, input fill_t style);
        logic [qsl_pkg::VALUE_W-1:0] run;
        int                          i;

        run = $urandom;
        for (i = 0; i < size; i++)
        begin
            case (style)
                FILL_RANDOM:  set_values.push_back($urandom);
                FILL_NARROW:  set_values.push_back($urandom_range(0, 15) - 8);
                FILL_EXTREME:
                    case ($urandom_range(0, 3))
                        0:       set_values.push_back(32'h8000_0000);
                        1:       set_values.push_back(32'h7fff_ffff);
                        2:       set_values.push_back(32'h0000_0000);
                        default: set_values.push_back(32'hffff_ffff);
                    endcase
                FILL_RISING:
                begin
                    run = run + $urandom_range(0, 1000);
                    set_values.push_back(run);
                end
                default:
                begin
                    run = run - $urandom_range(0, 1000);
                    set_values.push_back(run);
                end
            endcase
        end
    endtask

    // offer each value, tlast on the final one, then clear the set
    task automatic send_set();
        int gap;
        int i;

        for (i = 0; i < set_values.size(); i++)
        begin
            gap = draw_gap(tx_calm);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= set_values[i];
            s_axis_tlast  <= (i == set_values.size() - 1);
            @(posedge clk);
            while (!s_axis_tready) @(posedge clk);
            items_sent++;
        end
        set_values.delete();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : receiver
        int gap;
        int taken;

        m_axis_tready <= 1'b0;
        taken = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        gap = draw_gap(1'b0);
        forever
        begin
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            taken++;
            // hold off long enough for the next set to back up at the input
            if (taken == HOLD_AT)
                gap = HOLD_CYCLES;
            else
                gap = draw_gap((taken / 48) % 3 == 2);
        end
    end

    initial
    begin : stimulus
        int    set_idx;
        int    size;
        fill_t style;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_values.push_back(32'h8000_0000);
        send_set();
        set_values.push_back(32'h7fff_ffff);
        send_set();
        set_values.push_back(32'h7fff_ffff);
        set_values.push_back(32'h8000_0000);
        send_set();
        set_values.push_back(0);
        set_values.push_back(-1);
        set_values.push_back(1);
        set_values.push_back(0);
        send_set();
        set_values.push_back(5);
        set_values.push_back(5);
        set_values.push_back(5);
        send_set();
        set_values.push_back(-3);
        set_values.push_back(-2);
        set_values.push_back(-1);
        set_values.push_back(0);
        set_values.push_back(1);
        send_set();
        set_values.push_back(7);
        set_values.push_back(3);
        set_values.push_back(0);
        set_values.push_back(-4);
        set_values.push_back(-9);
        send_set();

        items_sent = 0;
        set_idx = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            tx_calm = (set_idx % 5 == 3);
            style = fill_t'($urandom_range(0, 4));
            if (set_idx == 4)
            begin
                size  = DEPTH;
                style = FILL_RISING;
            end
            else if (set_idx == 11)
                size = DEPTH + $urandom_range(1, 6);
            else if ($urandom_range(0, 7) == 0)
                size = $urandom_range(13, 40);
            else
                size = $urandom_range(1, 12);
            fill_set(size, style);
            send_set();
            set_idx++;
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
